/* rtl/ma_crossover_trade_tracker_defines.svh */
// Assertion macros shared by the tracker RTL.
`ifndef MA_CROSSOVER_TRADE_TRACKER_DEFINES_SVH
`define MA_CROSSOVER_TRADE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mct assertion failed");

// Next-cycle implication, checked while out of reset.
`define MCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mct assertion failed");

`endif

/* rtl/mct_pkg.sv */
// Types, constants and codes of the moving-average crossover trade tracker.
package mct_pkg;

    localparam int PRICE_BITS       = 32;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int LEN_BITS         = 7;
    localparam int RET_BITS         = 48;
    localparam int DD_BITS          = 47;
    localparam int FRAC_BITS        = 16;
    localparam int PCT_SCALE        = 100;
    // diff * 100 fits PRICE_BITS + 7 bits
    localparam int NUM_BITS         = PRICE_BITS + 7;
    localparam int QUO_BITS         = NUM_BITS + FRAC_BITS;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [LEN_BITS-1:0] FAST_LEN_RST = LEN_BITS'(9);
    localparam logic [LEN_BITS-1:0] SLOW_LEN_RST = LEN_BITS'(26);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_LEN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW_LEN = 1'b1;

    localparam logic [RET_BITS-1:0] S48_MAX = {1'b0, {(RET_BITS-1){1'b1}}};
    localparam logic [RET_BITS-1:0] S48_MIN = {1'b1, {(RET_BITS-1){1'b0}}};
    localparam logic [DD_BITS-1:0]  DD_MAX  = {DD_BITS{1'b1}};

    typedef enum logic [1:0] {
        POS_FLAT  = 2'd0,
        POS_LONG  = 2'd1,
        POS_SHORT = 2'd2
    } t_pos;

    typedef struct packed {
        logic [31:0] close_price;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                 position_now;
        logic                       windows_full;
        logic                       trade_closed;
        logic signed [RET_BITS-1:0] trade_return;
        logic signed [RET_BITS-1:0] total_profit;
        logic [DD_BITS-1:0]         worst_drawdown;
        logic                       price_error;
    } t_out_item;

    // classified item, front to back
    typedef struct packed {
        t_pos                  pos;
        logic                  full;
        logic                  close;
        logic                  err;
        logic                  restart;
        logic [PRICE_BITS-1:0] gain;
        logic [PRICE_BITS-1:0] base;
        logic [PRICE_BITS-1:0] divisor;
    } t_cmd;

endpackage

/* rtl/mct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/mct_queue.sv */
// Two-entry command queue between the front and back parts.
module mct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mct_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mct_pkg::t_cmd o_cmd
);
    import mct_pkg::*;

    localparam int PB = $clog2(QUEUE_DEPTH);
    localparam int CB = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PB-1:0] r_wp, r_rp;
    logic [CB-1:0] r_cnt;

    assign o_full  = (r_cnt == CB'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PB'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PB'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* rtl/mct_front.sv */
// Front part: takes prices, keeps the ring and window sums, classifies crossings.
module mct_front #(
    parameter int WINDOW_DEPTH = mct_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mct_pkg::t_in_item               i_in_item,
    input  logic [mct_pkg::LEN_BITS-1:0]    i_fast_len,
    input  logic [mct_pkg::LEN_BITS-1:0]    i_slow_len,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output mct_pkg::t_cmd                   o_q_cmd
);
    import mct_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = PRICE_BITS + LW;
    localparam int MW = SW + LW;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L  = LW'(WINDOW_DEPTH);

    typedef enum logic [2:0] {F_IDLE, F_SUM, F_MUL, F_CMP, F_PUSH} t_fstate;

    t_fstate               r_state;
    logic [AW-1:0]         r_wr, r_rd_ptr;
    logic [LW-1:0]         r_seen, r_k, r_dk;
    logic [SW-1:0]         r_fast, r_slow;
    logic [MW-1:0]         r_pf, r_ps;
    t_pos                  r_pos;
    logic [PRICE_BITS-1:0] r_entry, r_price;
    logic                  r_restart, r_rd_valid;
    t_cmd                  r_cmd;

    logic [LW-1:0]         fl, sl, max_len, n_cnt, base_seen;
    logic [AW-1:0]         base_wr;
    t_pos                  base_pos, n_pos;
    logic [PRICE_BITS-1:0] base_entry, price, n_entry, rd_data;
    logic                  accept, wr_en, issue, full;
    t_cmd                  n_cmd, err_cmd;

    function automatic logic [LW-1:0] clamp_len(input logic [LEN_BITS-1:0] r);
        int unsigned v;
        v = 32'(r);
        if (v == 0) begin
            v = 1;
        end else if (v > WINDOW_DEPTH) begin
            v = WINDOW_DEPTH;
        end
        return LW'(v);
    endfunction

    assign o_in_ready = (r_state == F_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign price      = i_in_item.close_price[PRICE_BITS-1:0];
    assign o_q_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_q_cmd    = r_cmd;

    // effective lengths and read count
    always_comb begin
        fl      = clamp_len(i_fast_len);
        sl      = clamp_len(i_slow_len);
        max_len = (fl > sl) ? fl : sl;
        n_cnt   = (r_seen < max_len) ? r_seen : max_len;
        issue   = (r_state == F_SUM) && (r_k < n_cnt);
    end

    // state as seen after an optional restart, and the zero-price command
    always_comb begin
        base_seen       = i_in_item.restart ? '0 : r_seen;
        base_wr         = i_in_item.restart ? '0 : r_wr;
        base_pos        = i_in_item.restart ? POS_FLAT : r_pos;
        base_entry      = i_in_item.restart ? '0 : r_entry;
        wr_en           = accept && (price != '0);
        err_cmd         = '0;
        err_cmd.pos     = base_pos;
        err_cmd.full    = (base_seen >= sl);
        err_cmd.err     = 1'b1;
        err_cmd.restart = i_in_item.restart;
    end

    // crossing decision
    always_comb begin
        full          = (r_seen >= sl);
        n_pos         = r_pos;
        n_entry       = r_entry;
        n_cmd         = '0;
        n_cmd.full    = full;
        n_cmd.restart = r_restart;
        if (full && (r_pf > r_ps) && (r_pos != POS_LONG)) begin
            if (r_pos == POS_SHORT) begin
                n_cmd.close   = 1'b1;
                n_cmd.gain    = r_entry;
                n_cmd.base    = r_price;
                n_cmd.divisor = r_price;
            end
            n_pos   = POS_LONG;
            n_entry = r_price;
        end else if (full && (r_pf < r_ps) && (r_pos != POS_SHORT)) begin
            if (r_pos == POS_LONG) begin
                n_cmd.close   = 1'b1;
                n_cmd.gain    = r_price;
                n_cmd.base    = r_entry;
                n_cmd.divisor = r_entry;
            end
            n_pos   = POS_SHORT;
            n_entry = r_price;
        end
        n_cmd.pos = n_pos;
    end

    mct_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (base_wr),
        .i_wdata (price),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_data)
    );

    // front sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_wr       <= '0;
            r_seen     <= '0;
            r_pos      <= POS_FLAT;
            r_entry    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_pos     <= base_pos;
                        r_entry   <= base_entry;
                        r_restart <= i_in_item.restart;
                        r_price   <= price;
                        r_k       <= '0;
                        r_dk      <= '0;
                        r_fast    <= '0;
                        r_slow    <= '0;
                        r_rd_ptr  <= base_wr;
                        if (price == '0) begin
                            r_seen  <= base_seen;
                            r_wr    <= base_wr;
                            r_cmd   <= err_cmd;
                            r_state <= F_PUSH;
                        end else begin
                            r_seen  <= (base_seen == DEPTH_L) ? DEPTH_L : base_seen + 1'b1;
                            r_wr    <= (base_wr == LAST_IDX) ? '0 : base_wr + 1'b1;
                            r_state <= F_SUM;
                        end
                    end
                end
                F_SUM: begin
                    if (issue) begin
                        r_k      <= r_k + 1'b1;
                        r_rd_ptr <= (r_rd_ptr == '0) ? LAST_IDX : r_rd_ptr - 1'b1;
                    end
                    if (r_rd_valid) begin
                        r_dk <= r_dk + 1'b1;
                        if (r_dk < fl) begin
                            r_fast <= r_fast + SW'(rd_data);
                        end
                        if (r_dk < sl) begin
                            r_slow <= r_slow + SW'(rd_data);
                        end
                    end
                    if (!issue && !r_rd_valid) begin
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_pf    <= MW'(r_fast) * MW'(sl);
                    r_ps    <= MW'(r_slow) * MW'(fl);
                    r_state <= F_CMP;
                end
                F_CMP: begin
                    r_pos   <= n_pos;
                    r_entry <= n_entry;
                    r_cmd   <= n_cmd;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

/* rtl/mct_back.sv */
// Back part: divides out the trade return, books profit, peak and drawdown.
module mct_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  mct_pkg::t_cmd      i_q_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mct_pkg::t_out_item o_out_item
);
    import mct_pkg::*;

    localparam int CW = $clog2(QUO_BITS + 1);

    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_DIV, B_RET, B_PROF, B_PEAK, B_DD, B_OUT
    } t_bstate;

    t_bstate                    r_state;
    t_cmd                       r_cmd;
    logic                       r_neg;
    logic [QUO_BITS-1:0]        r_quo;
    logic [PRICE_BITS-1:0]      r_rem;
    logic [CW-1:0]              r_cnt;
    logic signed [RET_BITS-1:0] r_ret, r_profit, r_peak;
    logic [DD_BITS-1:0]         r_dd;

    logic                  neg, qbit, sat;
    logic [PRICE_BITS-1:0] diff, rem_next;
    logic [PRICE_BITS:0]   rem_sh;
    logic [RET_BITS-1:0]   mag;
    logic [RET_BITS:0]     psum, dd_raw;
    logic [DD_BITS-1:0]    dd_cl;

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;

    // sign and magnitude of the price move
    always_comb begin
        neg  = (r_cmd.gain < r_cmd.base);
        diff = neg ? r_cmd.base - r_cmd.gain : r_cmd.gain - r_cmd.base;
    end

    // one restoring divide step
    always_comb begin
        rem_sh   = {r_rem, r_quo[QUO_BITS-1]};
        qbit     = (rem_sh >= {1'b0, r_cmd.divisor});
        rem_next = qbit ? PRICE_BITS'(rem_sh - {1'b0, r_cmd.divisor})
                        : rem_sh[PRICE_BITS-1:0];
    end

    // saturation, profit sum and drawdown
    always_comb begin
        sat    = (r_quo[QUO_BITS-1:RET_BITS-1] != '0);
        mag    = r_quo[RET_BITS-1:0];
        psum   = {r_profit[RET_BITS-1], r_profit} + {r_ret[RET_BITS-1], r_ret};
        dd_raw = {r_peak[RET_BITS-1], r_peak} - {r_profit[RET_BITS-1], r_profit};
        dd_cl  = (dd_raw[RET_BITS:DD_BITS] != '0) ? DD_MAX : dd_raw[DD_BITS-1:0];
    end

    // back sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_profit    <= '0;
            r_peak      <= '0;
            r_dd        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // taken result frees the register unless a new one loads now
            if (o_out_valid && i_out_ready && (r_state != B_OUT)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd <= i_q_cmd;
                        r_ret <= '0;
                        if (i_q_cmd.restart) begin
                            r_profit <= '0;
                            r_peak   <= '0;
                            r_dd     <= '0;
                        end
                        r_state <= i_q_cmd.close ? B_MUL : B_OUT;
                    end
                end
                B_MUL: begin
                    r_neg   <= neg;
                    r_quo   <= {NUM_BITS'(NUM_BITS'(diff) * NUM_BITS'(PCT_SCALE)),
                                {FRAC_BITS{1'b0}}};
                    r_rem   <= '0;
                    r_cnt   <= CW'(QUO_BITS);
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_quo <= {r_quo[QUO_BITS-2:0], qbit};
                    r_rem <= rem_next;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= B_RET;
                    end
                end
                B_RET: begin
                    if (r_cmd.divisor == '0) begin
                        r_ret <= '0;
                    end else if (sat) begin
                        r_ret <= r_neg ? S48_MIN : S48_MAX;
                    end else begin
                        r_ret <= r_neg ? ~mag + 1'b1 : mag;
                    end
                    r_state <= B_PROF;
                end
                B_PROF: begin
                    if (psum[RET_BITS] != psum[RET_BITS-1]) begin
                        r_profit <= psum[RET_BITS] ? S48_MIN : S48_MAX;
                    end else begin
                        r_profit <= psum[RET_BITS-1:0];
                    end
                    r_state <= B_PEAK;
                end
                B_PEAK: begin
                    if (r_profit > r_peak) begin
                        r_peak <= r_profit;
                    end
                    r_state <= B_DD;
                end
                B_DD: begin
                    if (dd_cl > r_dd) begin
                        r_dd <= dd_cl;
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid                <= 1'b1;
                        o_out_item.position_now   <= r_cmd.pos;
                        o_out_item.windows_full   <= r_cmd.full;
                        o_out_item.trade_closed   <= r_cmd.close;
                        o_out_item.trade_return   <= r_ret;
                        o_out_item.total_profit   <= r_profit;
                        o_out_item.worst_drawdown <= r_dd;
                        o_out_item.price_error    <= r_cmd.err;
                        r_state                   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

/* rtl/ma_crossover_trade_tracker.sv */
// Moving-average crossover trade tracker, top level.
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_item) carries one closing price
//   and a restart flag per transaction. Output channel (o_out_valid / i_out_ready,
//   o_out_item) returns exactly one result transaction per input.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes fast_len / slow_len;
//   write only while the block is idle.
// Flow:
//   The front reads back n = min(seen, max(fast, slow)) ring entries, one per
//   cycle from the ring RAM read port, up to WINDOW_DEPTH. The back part passes
//   an item that closes no trade straight to the output, and one that does
//   through a restoring divide plus booking. Front and back overlap through
//   a 2-entry command queue; the front takes a new price only once the
//   command of the last one is pushed.
// Reset: control state clears, lengths return to 9 and 26; the ring needs no
//   clearing pass since only entries written since the last restart are read.
// Stall: a held result sits in the output register; the back part and then
//   the queue fill, after which the front stops taking input.
module ma_crossover_trade_tracker #(
    parameter int WINDOW_DEPTH = mct_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mct_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mct_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [mct_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [mct_pkg::LEN_BITS-1:0]     i_cfg_data
);
    import mct_pkg::*;
    `include "ma_crossover_trade_tracker_defines.svh"

    logic [LEN_BITS-1:0] r_fast_len, r_slow_len;
    logic                q_push, q_pop, q_full, q_empty;
    logic                chk_err, chk_open;
    t_cmd                push_cmd, pop_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_len <= FAST_LEN_RST;
            r_slow_len <= SLOW_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FAST_LEN: r_fast_len <= i_cfg_data;
                CFG_SLOW_LEN: r_slow_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mct_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_fast_len (r_fast_len),
        .i_slow_len (r_slow_len),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (push_cmd)
    );

    mct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (pop_cmd)
    );

    mct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_cmd     (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // checks
    assign chk_err  = o_out_valid && o_out_item.price_error;
    assign chk_open = o_out_valid && !o_out_item.trade_closed;

    `MCT_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    `MCT_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `MCT_ASSERT_IMPLY(a_err_no_close, i_clk, i_rst_n, chk_err, !o_out_item.trade_closed)
    `MCT_ASSERT_IMPLY(a_ret_zero_open, i_clk, i_rst_n, chk_open, o_out_item.trade_return == '0)
endmodule
